FILE: rtl/rv32c_eu_pkg.sv
// Shared types and constants for the RV32C execute unit.
// Used by rv32c_eu_regfile and rv32c_execute_unit_core; depends on nothing else.
package rv32c_eu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned RegAddrW = 5;
  localparam int unsigned CmdW     = 5;
  localparam int unsigned InstrW   = 16;

  // Bit 5 of a shift amount marks an encoding that must not write.
  localparam int unsigned ShamtResBit = 5;
  // Jump targets taken from a register drop bit 0.
  localparam logic [XLEN-1:0] JumpAlignMask = ~(XLEN'(1));
  localparam logic [RegAddrW-1:0] RegZero = '0;
  localparam logic [RegAddrW-1:0] RegRa   = RegAddrW'(1);
  localparam logic [RegAddrW-1:0] RegSp   = RegAddrW'(2);

  typedef enum logic [CmdW-1:0] {
    CMD_LWSP     = 5'd0,
    CMD_SWSP     = 5'd1,
    CMD_LW       = 5'd2,
    CMD_SW       = 5'd3,
    CMD_J        = 5'd4,
    CMD_JAL      = 5'd5,
    CMD_JR       = 5'd6,
    CMD_JALR     = 5'd7,
    CMD_BEQZ     = 5'd8,
    CMD_BNEZ     = 5'd9,
    CMD_LI       = 5'd10,
    CMD_LUI      = 5'd11,
    CMD_ADDI     = 5'd12,
    CMD_ADDI16SP = 5'd13,
    CMD_ADDI4SPN = 5'd14,
    CMD_SLLI     = 5'd15,
    CMD_SRLI     = 5'd16,
    CMD_SRAI     = 5'd17,
    CMD_ANDI     = 5'd18,
    CMD_MV       = 5'd19,
    CMD_ADD      = 5'd20,
    CMD_AND      = 5'd21,
    CMD_OR       = 5'd22,
    CMD_XOR      = 5'd23,
    CMD_SUB      = 5'd24,
    CMD_LD_RET   = 5'd25
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [InstrW-1:0] instruction;
    logic [XLEN-1:0]   pc;
    logic [XLEN-1:0]   load_data;
  } exu_in_t;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            redirected;
    logic            mem_request;
    logic            mem_is_write;
    logic [XLEN-1:0] mem_address;
    logic [XLEN-1:0] mem_write_data;
    logic            trap;
    logic            ebreak;
  } exu_out_t;

  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [XLEN-1:0]     data;
  } rf_wr_t;

endpackage

FILE: rtl/rv32c_eu_regfile.sv
// Integer register file for the RV32C execute unit: two registered read ports,
// one write port, per-entry valid bits so reset reads as zero. Uses rv32c_eu_pkg.
module rv32c_eu_regfile #(
  parameter int unsigned REGISTER_COUNT = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [rv32c_eu_pkg::RegAddrW-1:0] rd_addr_a_i,
  input  logic [rv32c_eu_pkg::RegAddrW-1:0] rd_addr_b_i,
  output logic [rv32c_eu_pkg::XLEN-1:0]     rd_data_a_o,
  output logic [rv32c_eu_pkg::XLEN-1:0]     rd_data_b_o,
  input  rv32c_eu_pkg::rf_wr_t              wr_i
);

  localparam int unsigned IdxW = $clog2(REGISTER_COUNT);
  localparam logic [rv32c_eu_pkg::RegAddrW:0] RegCount =
    REGISTER_COUNT[rv32c_eu_pkg::RegAddrW:0];

  logic [rv32c_eu_pkg::XLEN-1:0] mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0]     valid_q;

  logic [rv32c_eu_pkg::XLEN-1:0] rd_a_q, rd_b_q;
  logic                          zero_a_q, zero_a_d;
  logic                          zero_b_q, zero_b_d;
  logic                          fwd_a, fwd_b;
  logic                          wr_ok;
  logic [IdxW-1:0]               idx_a, idx_b, idx_w;

  assign idx_a = rd_addr_a_i[IdxW-1:0];
  assign idx_b = rd_addr_b_i[IdxW-1:0];
  assign idx_w = wr_i.addr[IdxW-1:0];

  assign wr_ok = wr_i.en && (wr_i.addr != rv32c_eu_pkg::RegZero) &&
                 ({1'b0, wr_i.addr} < RegCount);

  // A write landing on the same edge as a read is forwarded into the read register.
  assign fwd_a = wr_ok && (wr_i.addr == rd_addr_a_i);
  assign fwd_b = wr_ok && (wr_i.addr == rd_addr_b_i);

  assign zero_a_d = !((rd_addr_a_i != rv32c_eu_pkg::RegZero) &&
                      ({1'b0, rd_addr_a_i} < RegCount) && (valid_q[idx_a] || fwd_a));
  assign zero_b_d = !((rd_addr_b_i != rv32c_eu_pkg::RegZero) &&
                      ({1'b0, rd_addr_b_i} < RegCount) && (valid_q[idx_b] || fwd_b));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[idx_w] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_a_q <= fwd_a ? wr_i.data : mem[idx_a];
      rd_b_q <= fwd_b ? wr_i.data : mem[idx_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      zero_a_q <= 1'b1;
      zero_b_q <= 1'b1;
    end else begin
      if (wr_ok) begin
        valid_q[idx_w] <= 1'b1;
      end
      if (rd_en_i) begin
        zero_a_q <= zero_a_d;
        zero_b_q <= zero_b_d;
      end
    end
  end

  assign rd_data_a_o = zero_a_q ? '0 : rd_a_q;
  assign rd_data_b_o = zero_b_q ? '0 : rd_b_q;

endmodule

FILE: rtl/rv32c_execute_unit_core.sv
// Top level of the RV32C execute unit: input stage with register reads,
// execute logic, result register. Uses rv32c_eu_pkg and rv32c_eu_regfile.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   in       | input     | in_valid_i/in_ready_o  | in_data_i  (exu_in_t)
//   out      | output    | out_valid_o/out_ready_i| out_data_o (exu_out_t)
//
// One instruction per cycle unless the output stalls; each is held in s1_q, then out_q.
// Operands are read from the register file on the input transfer; the write of
// the instruction ahead is forwarded into that read, so no bubbles are needed.
// Reset clears the register file valid bits and the pending load; all registers
// then read zero. A stalled result holds the input stage, which still accepts one
// new item while it is empty.
module rv32c_execute_unit_core #(
  parameter int unsigned REGISTER_COUNT = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rv32c_eu_pkg::exu_in_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rv32c_eu_pkg::exu_out_t out_data_o
);

  localparam int unsigned XLEN = rv32c_eu_pkg::XLEN;
  localparam int unsigned AW   = rv32c_eu_pkg::RegAddrW;

  logic                  s1_valid_q;
  rv32c_eu_pkg::exu_in_t s1_q;
  logic                  out_valid_q;
  rv32c_eu_pkg::exu_out_t out_q, out_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [AW-1:0]         pend_reg_q, pend_reg_d;

  logic                  in_accept, advance;
  logic [AW-1:0]         rd_addr_a, rd_addr_b;
  logic [XLEN-1:0]       op_a, op_b;
  rv32c_eu_pkg::rf_wr_t  wr;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // Read port selection from the incoming instruction.
  always_comb begin
    logic [15:0] ii;
    ii = in_data_i.instruction;
    unique case (rv32c_eu_pkg::cmd_e'(in_data_i.command)) inside
      rv32c_eu_pkg::CMD_LWSP, rv32c_eu_pkg::CMD_SWSP,
      rv32c_eu_pkg::CMD_ADDI16SP, rv32c_eu_pkg::CMD_ADDI4SPN:
        rd_addr_a = rv32c_eu_pkg::RegSp;
      rv32c_eu_pkg::CMD_LW, rv32c_eu_pkg::CMD_SW, rv32c_eu_pkg::CMD_BEQZ,
      rv32c_eu_pkg::CMD_BNEZ, rv32c_eu_pkg::CMD_SRLI, rv32c_eu_pkg::CMD_SRAI,
      rv32c_eu_pkg::CMD_ANDI, rv32c_eu_pkg::CMD_AND, rv32c_eu_pkg::CMD_OR,
      rv32c_eu_pkg::CMD_XOR, rv32c_eu_pkg::CMD_SUB:
        rd_addr_a = {2'b01, ii[9:7]};
      rv32c_eu_pkg::CMD_JR, rv32c_eu_pkg::CMD_JALR, rv32c_eu_pkg::CMD_ADDI,
      rv32c_eu_pkg::CMD_SLLI, rv32c_eu_pkg::CMD_ADD:
        rd_addr_a = ii[11:7];
      default:
        rd_addr_a = rv32c_eu_pkg::RegZero;
    endcase
    unique case (rv32c_eu_pkg::cmd_e'(in_data_i.command)) inside
      rv32c_eu_pkg::CMD_SWSP, rv32c_eu_pkg::CMD_MV, rv32c_eu_pkg::CMD_ADD:
        rd_addr_b = ii[6:2];
      rv32c_eu_pkg::CMD_SW, rv32c_eu_pkg::CMD_AND, rv32c_eu_pkg::CMD_OR,
      rv32c_eu_pkg::CMD_XOR, rv32c_eu_pkg::CMD_SUB:
        rd_addr_b = {2'b01, ii[4:2]};
      default:
        rd_addr_b = rv32c_eu_pkg::RegZero;
    endcase
  end

  rv32c_eu_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .rd_data_a_o(op_a),
    .rd_data_b_o(op_b),
    .wr_i       (wr)
  );

  // Execute.
  always_comb begin
    logic [15:0]     i;
    logic [XLEN-1:0] pc_inc;
    logic [XLEN-1:0] imm_ci, imm_cj, imm_cb, imm_lui, imm_16sp, imm_4spn;
    logic [XLEN-1:0] imm_lwsp, imm_swsp, imm_lw;
    logic [5:0]      shamt;
    logic [AW-1:0]   r117, r62, r97, r42;

    i        = s1_q.instruction;
    pc_inc   = s1_q.pc + XLEN'(2);
    r117     = i[11:7];
    r62      = i[6:2];
    r97      = {2'b01, i[9:7]};
    r42      = {2'b01, i[4:2]};
    shamt    = {i[12], i[6:2]};
    imm_ci   = {{26{i[12]}}, i[12], i[6:2]};
    imm_cj   = {{20{i[12]}}, i[12], i[8], i[10:9], i[6], i[7], i[2], i[11], i[5:3], 1'b0};
    imm_cb   = {{23{i[12]}}, i[12], i[6:5], i[2], i[11:10], i[4:3], 1'b0};
    imm_lui  = {{14{i[12]}}, i[12], i[6:2], 12'b0};
    imm_16sp = {{22{i[12]}}, i[12], i[4:3], i[5], i[2], i[6], 4'b0};
    imm_4spn = {22'b0, i[10:7], i[12:11], i[5], i[6], 2'b0};
    imm_lwsp = {24'b0, i[3:2], i[12], i[6:4], 2'b0};
    imm_swsp = {24'b0, i[8:7], i[12:9], 2'b0};
    imm_lw   = {25'b0, i[5], i[12:10], i[6], 2'b0};

    out_d        = '0;
    out_d.next_pc = pc_inc;
    wr           = '0;
    pend_vld_d   = pend_vld_q;
    pend_reg_d   = pend_reg_q;

    unique case (rv32c_eu_pkg::cmd_e'(s1_q.command)) inside
      rv32c_eu_pkg::CMD_LWSP: begin
        out_d.mem_request = 1'b1;
        out_d.mem_address = op_a + imm_lwsp;
        pend_vld_d        = 1'b1;
        pend_reg_d        = r117;
      end
      rv32c_eu_pkg::CMD_SWSP: begin
        out_d.mem_request    = 1'b1;
        out_d.mem_is_write   = 1'b1;
        out_d.mem_address    = op_a + imm_swsp;
        out_d.mem_write_data = op_b;
      end
      rv32c_eu_pkg::CMD_LW: begin
        out_d.mem_request = 1'b1;
        out_d.mem_address = op_a + imm_lw;
        pend_vld_d        = 1'b1;
        pend_reg_d        = r42;
      end
      rv32c_eu_pkg::CMD_SW: begin
        out_d.mem_request    = 1'b1;
        out_d.mem_is_write   = 1'b1;
        out_d.mem_address    = op_a + imm_lw;
        out_d.mem_write_data = op_b;
      end
      rv32c_eu_pkg::CMD_J: begin
        out_d.next_pc    = s1_q.pc + imm_cj;
        out_d.redirected = 1'b1;
      end
      rv32c_eu_pkg::CMD_JAL: begin
        out_d.next_pc    = s1_q.pc + imm_cj;
        out_d.redirected = 1'b1;
        wr               = '{en: 1'b1, addr: rv32c_eu_pkg::RegRa, data: pc_inc};
      end
      rv32c_eu_pkg::CMD_JR: begin
        out_d.next_pc    = op_a & rv32c_eu_pkg::JumpAlignMask;
        out_d.redirected = 1'b1;
      end
      rv32c_eu_pkg::CMD_JALR: begin
        if (r117 == rv32c_eu_pkg::RegZero) begin
          out_d.ebreak = 1'b1;
        end else begin
          out_d.next_pc    = op_a & rv32c_eu_pkg::JumpAlignMask;
          out_d.redirected = 1'b1;
          wr               = '{en: 1'b1, addr: rv32c_eu_pkg::RegRa, data: pc_inc};
        end
      end
      rv32c_eu_pkg::CMD_BEQZ, rv32c_eu_pkg::CMD_BNEZ: begin
        if ((s1_q.command == rv32c_eu_pkg::CMD_BEQZ) == (op_a == '0)) begin
          out_d.next_pc    = s1_q.pc + imm_cb;
          out_d.redirected = 1'b1;
        end
      end
      rv32c_eu_pkg::CMD_LI: begin
        wr = '{en: 1'b1, addr: r117, data: imm_ci};
      end
      rv32c_eu_pkg::CMD_LUI: begin
        // Writes to sp or x0, and a zero immediate, are not a LUI.
        wr = '{en: (r117 != rv32c_eu_pkg::RegZero) && (r117 != rv32c_eu_pkg::RegSp) &&
                   (imm_lui != '0),
               addr: r117, data: imm_lui};
      end
      rv32c_eu_pkg::CMD_ADDI: begin
        wr = '{en: 1'b1, addr: r117, data: op_a + imm_ci};
      end
      rv32c_eu_pkg::CMD_ADDI16SP: begin
        out_d.trap = (imm_16sp == '0);
        wr = '{en: imm_16sp != '0, addr: rv32c_eu_pkg::RegSp, data: op_a + imm_16sp};
      end
      rv32c_eu_pkg::CMD_ADDI4SPN: begin
        out_d.trap = (imm_4spn == '0);
        wr = '{en: imm_4spn != '0, addr: r42, data: op_a + imm_4spn};
      end
      rv32c_eu_pkg::CMD_SLLI: begin
        wr = '{en: !shamt[rv32c_eu_pkg::ShamtResBit], addr: r117,
               data: op_a << shamt[4:0]};
      end
      rv32c_eu_pkg::CMD_SRLI: begin
        wr = '{en: !shamt[rv32c_eu_pkg::ShamtResBit], addr: r97,
               data: op_a >> shamt[4:0]};
      end
      rv32c_eu_pkg::CMD_SRAI: begin
        wr = '{en: !shamt[rv32c_eu_pkg::ShamtResBit], addr: r97,
               data: XLEN'($signed(op_a) >>> shamt[4:0])};
      end
      rv32c_eu_pkg::CMD_ANDI: begin
        wr = '{en: 1'b1, addr: r97, data: op_a & imm_ci};
      end
      rv32c_eu_pkg::CMD_MV: begin
        wr = '{en: 1'b1, addr: r117, data: op_b};
      end
      rv32c_eu_pkg::CMD_ADD: begin
        wr = '{en: 1'b1, addr: r117, data: op_a + op_b};
      end
      rv32c_eu_pkg::CMD_AND: begin
        wr = '{en: 1'b1, addr: r97, data: op_a & op_b};
      end
      rv32c_eu_pkg::CMD_OR: begin
        wr = '{en: 1'b1, addr: r97, data: op_a | op_b};
      end
      rv32c_eu_pkg::CMD_XOR: begin
        wr = '{en: 1'b1, addr: r97, data: op_a ^ op_b};
      end
      rv32c_eu_pkg::CMD_SUB: begin
        wr = '{en: 1'b1, addr: r97, data: op_a - op_b};
      end
      rv32c_eu_pkg::CMD_LD_RET: begin
        out_d.next_pc = s1_q.pc;
        wr            = '{en: pend_vld_q, addr: pend_reg_q, data: s1_q.load_data};
        pend_vld_d    = 1'b0;
      end
      default: begin
      end
    endcase

    // State changes only when the instruction actually leaves the input stage.
    if (!advance) begin
      wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pend_vld_q  <= 1'b0;
      pend_reg_q  <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        pend_vld_q  <= pend_vld_d;
        pend_reg_q  <= pend_reg_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
